### sv/mbd_pkg.sv
`timescale 1ns / 1ps
// Package for the mouse button and DPI controller.
// Holds register indexes, reset values and the configuration type; no dependencies.
package mbd_pkg;

	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned DataW    = 32;
	localparam int unsigned DpiW     = 12;
	localparam int unsigned PeriodW  = 16;
	localparam int unsigned CountW   = 8;
	localparam int unsigned TickW    = 32;
	localparam int unsigned CodeW    = 3;

	typedef enum logic [2:0] {
		REG_KEY_PERIOD      = 3'd0,
		REG_LED_PERIOD      = 3'd1,
		REG_BLINK_INTERVAL  = 3'd2,
		REG_TOGGLES_PER_SET = 3'd3,
		REG_DPI_STEP        = 3'd4,
		REG_DPI_MAX         = 3'd5
	} reg_idx_t;

	typedef enum logic [CodeW-1:0] {
		KEY_NONE   = 3'd0,
		KEY_LEFT   = 3'd1,
		KEY_RIGHT  = 3'd2,
		KEY_MIDDLE = 3'd3,
		KEY_DPI    = 3'd4
	} key_code_t;

	localparam logic [PeriodW-1:0] KeyPeriodRst     = 16'd20;
	localparam logic [PeriodW-1:0] LedPeriodRst     = 16'd100;
	localparam logic [PeriodW-1:0] BlinkIntervalRst = 16'd500;
	localparam logic [CountW-1:0]  TogglesRst       = 8'd6;
	localparam logic [DpiW-1:0]    DpiStepRst       = 12'd500;
	localparam logic [DpiW-1:0]    DpiMaxRst        = 12'd3000;
	localparam logic [DpiW-1:0]    DpiInitRst       = 12'd1500;
	localparam logic [CountW-1:0]  PendingMax       = 8'd255;

	typedef struct packed {
		logic [PeriodW-1:0] key_period;
		logic [PeriodW-1:0] led_period;
		logic [PeriodW-1:0] blink_interval;
		logic [CountW-1:0]  toggles_per_set;
		logic [DpiW-1:0]    dpi_step;
		logic [DpiW-1:0]    dpi_max;
	} cfg_t;

endpackage

### sv/mbd_regs.sv
`timescale 1ns / 1ps
// Configuration register file with an APB-style slave port.
// Depends on mbd_pkg for register indexes, reset values and cfg_t.
module mbd_regs import mbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [DataW-1:0]    pwdata,
	output logic [DataW-1:0]    prdata,
	output logic                pready,
	output cfg_t                cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[CfgAddrW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_period      <= KeyPeriodRst;
			cfg_q.led_period      <= LedPeriodRst;
			cfg_q.blink_interval  <= BlinkIntervalRst;
			cfg_q.toggles_per_set <= TogglesRst;
			cfg_q.dpi_step        <= DpiStepRst;
			cfg_q.dpi_max         <= DpiMaxRst;
		end else if (wr_en) begin
			unique case (idx)
				REG_KEY_PERIOD:      cfg_q.key_period      <= pwdata[PeriodW-1:0];
				REG_LED_PERIOD:      cfg_q.led_period      <= pwdata[PeriodW-1:0];
				REG_BLINK_INTERVAL:  cfg_q.blink_interval  <= pwdata[PeriodW-1:0];
				REG_TOGGLES_PER_SET: cfg_q.toggles_per_set <= pwdata[CountW-1:0];
				REG_DPI_STEP:        cfg_q.dpi_step        <= pwdata[DpiW-1:0];
				REG_DPI_MAX:         cfg_q.dpi_max         <= pwdata[DpiW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KEY_PERIOD:      prdata = {16'd0, cfg_q.key_period};
			REG_LED_PERIOD:      prdata = {16'd0, cfg_q.led_period};
			REG_BLINK_INTERVAL:  prdata = {16'd0, cfg_q.blink_interval};
			REG_TOGGLES_PER_SET: prdata = {24'd0, cfg_q.toggles_per_set};
			REG_DPI_STEP:        prdata = {20'd0, cfg_q.dpi_step};
			REG_DPI_MAX:         prdata = {20'd0, cfg_q.dpi_max};
			default:             prdata = '0;
		endcase
	end

endmodule

### sv/mouse_button_dpi_controller.sv
`timescale 1ns / 1ps
// Top level of the mouse button and DPI controller: input stage, tick logic, result register.
// Depends on mbd_pkg and mbd_regs.

// Each input item is one millisecond tick with four button levels; each produces exactly one
// result item. An item is latched into an input register, and once the result register is free
// or being taken the key step, DPI update and LED blink step are worked out in one pass and
// written to the state and the result register, so the block takes one item per clock while the
// output does not stall. The input side keeps accepting while a result waits, until both the
// input and result registers are full. The user must write registers only while no item is in
// flight; the block itself does not enforce this.
module mouse_button_dpi_controller import mbd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [DataW-1:0]    pwdata,
	output logic [DataW-1:0]    prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                left_pressed,
	input  logic                right_pressed,
	input  logic                middle_pressed,
	input  logic                dpi_pressed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                left_button,
	output logic                right_button,
	output logic                middle_button,
	output logic [DpiW-1:0]     dpi_value,
	output logic                dpi_changed,
	output logic                led_level
);

	cfg_t cfg;

	mbd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// input stage
	logic       valid_s1;
	logic [3:0] keys_s1;
	logic       advance;
	logic       in_take;

	// state
	logic [TickW-1:0]   tick_q;
	logic [TickW-1:0]   last_toggle_q;
	logic [PeriodW-1:0] key_timer_q;
	logic [PeriodW-1:0] led_timer_q;
	key_code_t          prev_code_q;
	logic [2:0]         latches_q;
	logic [DpiW-1:0]    dpi_q;
	logic               blink_q;
	logic [CountW-1:0]  pending_q;
	logic [CountW-1:0]  toggle_cnt_q;
	logic               led_q;

	// result register
	logic               out_valid_q;
	logic [2:0]         out_buttons_q;
	logic [DpiW-1:0]    out_dpi_q;
	logic               out_changed_q;
	logic               out_led_q;

	// next values
	logic [TickW-1:0]   tick_d;
	logic [TickW-1:0]   last_toggle_d;
	logic [TickW-1:0]   since_toggle;
	logic [PeriodW-1:0] key_dec;
	logic [PeriodW-1:0] led_dec;
	logic [PeriodW-1:0] key_timer_d;
	logic [PeriodW-1:0] led_timer_d;
	logic               key_fire;
	logic               led_fire;
	key_code_t          code;
	key_code_t          prev_code_d;
	logic [2:0]         latches_d;
	logic [DpiW:0]      dpi_sum;
	logic [DpiW-1:0]    dpi_d;
	logic               dpi_hit;
	logic               blink_k;
	logic [CountW-1:0]  pending_k;
	logic               blink_d;
	logic [CountW-1:0]  pending_d;
	logic [CountW-1:0]  toggle_inc;
	logic [CountW-1:0]  toggle_cnt_d;
	logic               led_d;
	logic               do_toggle;

	assign advance  = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			keys_s1 <= {dpi_pressed, middle_pressed, right_pressed, left_pressed};
		end
	end

	always_comb begin
		priority if (keys_s1[0]) code = KEY_LEFT;
		else if (keys_s1[1])    code = KEY_RIGHT;
		else if (keys_s1[2])    code = KEY_MIDDLE;
		else if (keys_s1[3])    code = KEY_DPI;
		else                    code = KEY_NONE;
	end

	always_comb begin
		tick_d   = tick_q + 32'd1;
		key_dec  = (key_timer_q != '0) ? key_timer_q - 16'd1 : '0;
		led_dec  = (led_timer_q != '0) ? led_timer_q - 16'd1 : '0;
		key_fire = (key_dec == '0);
		led_fire = (led_dec == '0);
		key_timer_d = key_fire ? cfg.key_period : key_dec;
		led_timer_d = led_fire ? cfg.led_period : led_dec;

		// key step
		latches_d   = latches_q;
		prev_code_d = prev_code_q;
		dpi_d       = dpi_q;
		dpi_hit     = 1'b0;
		blink_k     = blink_q;
		pending_k   = pending_q;
		dpi_sum     = {1'b0, dpi_q} + {1'b0, cfg.dpi_step};
		if (key_fire) begin
			for (int k = 0; k < 3; k++) begin
				if (code == key_code_t'(k + 1) && prev_code_q != key_code_t'(k + 1))
					latches_d[k] = 1'b1;
				if (prev_code_q == key_code_t'(k + 1) && code != key_code_t'(k + 1))
					latches_d[k] = 1'b0;
			end
			if (code == KEY_DPI && prev_code_q != KEY_DPI) begin
				dpi_hit = 1'b1;
				dpi_d   = (dpi_sum > {1'b0, cfg.dpi_max}) ? cfg.dpi_step : dpi_sum[DpiW-1:0];
				blink_k = 1'b1;
				if (pending_q != PendingMax) pending_k = pending_q + 8'd1;
			end
			prev_code_d = code;
		end

		// LED step
		since_toggle  = tick_d - last_toggle_q;
		do_toggle     = led_fire & blink_k & (since_toggle >= {16'd0, cfg.blink_interval});
		last_toggle_d = last_toggle_q;
		led_d         = led_q;
		toggle_cnt_d  = toggle_cnt_q;
		pending_d     = pending_k;
		blink_d       = blink_k;
		toggle_inc    = toggle_cnt_q + 8'd1;
		if (do_toggle) begin
			last_toggle_d = tick_d;
			led_d         = ~led_q;
			toggle_cnt_d  = toggle_inc;
			if (toggle_inc >= cfg.toggles_per_set) begin
				if (pending_k != '0) pending_d = pending_k - 8'd1;
				toggle_cnt_d = '0;
				led_d        = 1'b1;
			end
			if (pending_d == '0) blink_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			last_toggle_q <= '0;
			key_timer_q   <= KeyPeriodRst;
			led_timer_q   <= LedPeriodRst;
			prev_code_q   <= KEY_NONE;
			latches_q     <= '0;
			dpi_q         <= DpiInitRst;
			blink_q       <= 1'b0;
			pending_q     <= '0;
			toggle_cnt_q  <= '0;
			led_q         <= 1'b1;
		end else if (advance) begin
			tick_q        <= tick_d;
			last_toggle_q <= last_toggle_d;
			key_timer_q   <= key_timer_d;
			led_timer_q   <= led_timer_d;
			prev_code_q   <= prev_code_d;
			latches_q     <= latches_d;
			dpi_q         <= dpi_d;
			blink_q       <= blink_d;
			pending_q     <= pending_d;
			toggle_cnt_q  <= toggle_cnt_d;
			led_q         <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_buttons_q <= latches_d;
			out_dpi_q     <= dpi_d;
			out_changed_q <= dpi_hit;
			out_led_q     <= led_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign left_button   = out_buttons_q[0];
	assign right_button  = out_buttons_q[1];
	assign middle_button = out_buttons_q[2];
	assign dpi_value     = out_dpi_q;
	assign dpi_changed   = out_changed_q;
	assign led_level     = out_led_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!blink_q |-> pending_q == '0)
		else $error("pending blink sets while blinking is idle");

	a_toggle_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		toggle_cnt_q != PendingMax)
		else $error("toggle count ran past any set size");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid_q |=> out_valid_q)
		else $error("input stage did not move into a free result register");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(tick_q))
		else $error("tick counter moved without an item");

endmodule

### tb/tb_mouse_button_dpi_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for mouse_button_dpi_controller: a clocked driver and monitor,
// an in-bench model of the key, DPI and LED blink logic, and APB setup between phases.
// Depends on mbd_pkg and the controller RTL.
module tb_mouse_button_dpi_controller;
	import mbd_pkg::*;

	typedef struct packed {
		logic dpi;
		logic middle;
		logic right;
		logic left;
	} tick_t;

	typedef struct packed {
		logic           left;
		logic           right;
		logic           middle;
		logic [DpiW-1:0] dpi;
		logic           changed;
		logic           led;
	} report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CfgAddrW-1:0] paddr = '0;
	logic [DataW-1:0]    pwdata = '0;
	logic [DataW-1:0]    prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                left_pressed = 1'b0;
	logic                right_pressed = 1'b0;
	logic                middle_pressed = 1'b0;
	logic                dpi_pressed = 1'b0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                left_button;
	logic                right_button;
	logic                middle_button;
	logic [DpiW-1:0]     dpi_value;
	logic                dpi_changed;
	logic                led_level;

	tick_t   ticks_to_send[$];
	report_t reports_due[$];
	int      mismatches = 0;

	cfg_t live_cfg = '{KeyPeriodRst, LedPeriodRst, BlinkIntervalRst, TogglesRst,
		DpiStepRst, DpiMaxRst};
	logic [TickW-1:0]   tick_cnt = '0;
	logic [TickW-1:0]   last_toggle = '0;
	logic [PeriodW-1:0] key_tmr = KeyPeriodRst;
	logic [PeriodW-1:0] led_tmr = LedPeriodRst;
	key_code_t          prev_code = KEY_NONE;
	logic [2:0]         latches = '0;
	logic [DpiW-1:0]    dpi_now = DpiInitRst;
	logic               blinking = 1'b0;
	logic [CountW-1:0]  sets_waiting = '0;
	logic [CountW-1:0]  toggles_done = '0;
	logic               led_now = 1'b1;

	tick_t held;
	int    gap_left = 0;
	int    calm_in = 0;
	int    stall_left = 0;
	int    calm_out = 0;

	logic [3:0] directed [24] = '{4'b0000, 4'b1111, 4'b0000, 4'b0010, 4'b0100, 4'b1000,
		4'b0000, 4'b1000, 4'b1000, 4'b1100, 4'b1010, 4'b0011, 4'b0001, 4'b1001, 4'b1000,
		4'b0000, 4'b1000, 4'b0000, 4'b1000, 4'b0110, 4'b0000, 4'b0000, 4'b0000, 4'b0000};

	mouse_button_dpi_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.left_pressed(left_pressed), .right_pressed(right_pressed),
		.middle_pressed(middle_pressed), .dpi_pressed(dpi_pressed),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_button(left_button), .right_button(right_button),
		.middle_button(middle_button), .dpi_value(dpi_value),
		.dpi_changed(dpi_changed), .led_level(led_level)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void run_tick(input tick_t t);
		key_code_t         code;
		logic [DpiW:0]     sum;
		logic              hit;
		report_t           r;
		hit = 1'b0;
		tick_cnt = tick_cnt + 1'b1;
		if (key_tmr != 0) key_tmr = key_tmr - 1'b1;
		if (led_tmr != 0) led_tmr = led_tmr - 1'b1;
		if (key_tmr == 0) begin
			key_tmr = live_cfg.key_period;
			if (t.left) code = KEY_LEFT;
			else if (t.right) code = KEY_RIGHT;
			else if (t.middle) code = KEY_MIDDLE;
			else if (t.dpi) code = KEY_DPI;
			else code = KEY_NONE;
			if (code != prev_code) begin
				case (prev_code)
					KEY_LEFT:   latches[0] = 1'b0;
					KEY_RIGHT:  latches[1] = 1'b0;
					KEY_MIDDLE: latches[2] = 1'b0;
					default: ;
				endcase
				case (code)
					KEY_LEFT:   latches[0] = 1'b1;
					KEY_RIGHT:  latches[1] = 1'b1;
					KEY_MIDDLE: latches[2] = 1'b1;
					KEY_DPI: begin
						sum = {1'b0, dpi_now} + {1'b0, live_cfg.dpi_step};
						dpi_now = (sum > {1'b0, live_cfg.dpi_max}) ? live_cfg.dpi_step
							: sum[DpiW-1:0];
						blinking = 1'b1;
						if (sets_waiting != PendingMax) sets_waiting = sets_waiting + 1'b1;
						hit = 1'b1;
					end
					default: ;
				endcase
			end
			prev_code = code;
		end
		if (led_tmr == 0) begin
			led_tmr = live_cfg.led_period;
			if (blinking && (tick_cnt - last_toggle) >= {16'b0, live_cfg.blink_interval}) begin
				last_toggle = tick_cnt;
				led_now = ~led_now;
				toggles_done = toggles_done + 1'b1;
				if (toggles_done >= live_cfg.toggles_per_set) begin
					if (sets_waiting != 0) sets_waiting = sets_waiting - 1'b1;
					toggles_done = '0;
					led_now = 1'b1;
				end
				if (sets_waiting == 0) blinking = 1'b0;
			end
		end
		r.left = latches[0];
		r.right = latches[1];
		r.middle = latches[2];
		r.dpi = dpi_now;
		r.changed = hit;
		r.led = led_now;
		reports_due.push_back(r);
	endfunction

	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// hold the item while stalled, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			left_pressed <= 1'b0;
			right_pressed <= 1'b0;
			middle_pressed <= 1'b0;
			dpi_pressed <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				run_tick(held);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (ticks_to_send.size() > 0) begin
					held = ticks_to_send.pop_front();
					left_pressed <= held.left;
					right_pressed <= held.right;
					middle_pressed <= held.middle;
					dpi_pressed <= held.dpi;
					in_valid <= 1'b1;
					gap_left = pick_idle(calm_in);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reports_due.size() == 0) begin
					$error("result item with no expectation waiting");
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					check_field("left_button", 32'(want.left), 32'(left_button));
					check_field("right_button", 32'(want.right), 32'(right_button));
					check_field("middle_button", 32'(want.middle), 32'(middle_button));
					check_field("dpi_value", 32'(want.dpi), 32'(dpi_value));
					check_field("dpi_changed", 32'(want.changed), 32'(dpi_changed));
					check_field("led_level", 32'(want.led), 32'(led_level));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_idle(calm_out);
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_KEY_PERIOD:      live_cfg.key_period = val[PeriodW-1:0];
			REG_LED_PERIOD:      live_cfg.led_period = val[PeriodW-1:0];
			REG_BLINK_INTERVAL:  live_cfg.blink_interval = val[PeriodW-1:0];
			REG_TOGGLES_PER_SET: live_cfg.toggles_per_set = val[CountW-1:0];
			REG_DPI_STEP:        live_cfg.dpi_step = val[DpiW-1:0];
			REG_DPI_MAX:         live_cfg.dpi_max = val[DpiW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_KEY_PERIOD, DataW'(c.key_period));
		write_reg(REG_LED_PERIOD, DataW'(c.led_period));
		write_reg(REG_BLINK_INTERVAL, DataW'(c.blink_interval));
		write_reg(REG_TOGGLES_PER_SET, DataW'(c.toggles_per_set));
		write_reg(REG_DPI_STEP, DataW'(c.dpi_step));
		write_reg(REG_DPI_MAX, DataW'(c.dpi_max));
	endtask

	task automatic drain();
		do @(negedge clk);
		while (!(ticks_to_send.size() == 0 && !in_valid && reports_due.size() == 0));
	endtask

	function automatic cfg_t pick_settings();
		cfg_t c;
		int   r;
		c.key_period = PeriodW'($urandom_range(1, 4));
		c.led_period = PeriodW'($urandom_range(1, 4));
		c.blink_interval = ($urandom_range(0, 9) == 0) ? PeriodW'($urandom_range(200, 600))
			: PeriodW'($urandom_range(1, 12));
		r = $urandom_range(0, 7);
		c.toggles_per_set = (r == 0) ? CountW'(1) : (r == 1) ? PendingMax
			: CountW'($urandom_range(1, 8));
		c.dpi_step = ($urandom_range(0, 3) == 0) ? DpiW'($urandom_range(1, 4095))
			: DpiW'($urandom_range(1, 1200));
		c.dpi_max = DpiW'($urandom_range(1, 4095));
		return c;
	endfunction

	function automatic void queue_button_runs(input int count, input int hold_max,
		input logic [3:0] allow);
		tick_t t;
		int    run;
		while (count > 0) begin
			if ($urandom_range(0, 9) < 7) t = tick_t'(4'b0001 << $urandom_range(0, 4));
			else t = tick_t'($urandom_range(0, 15));
			t = tick_t'(t & allow);
			run = $urandom_range(1, hold_max);
			while (run > 0 && count > 0) begin
				ticks_to_send.push_back(t);
				run--;
				count--;
			end
		end
	endfunction

	initial begin
		cfg_t c;
		int   i;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		apply_settings('{16'd1, 16'd1, 16'd2, 8'd2, 12'd1000, 12'd3000});
		@(negedge clk);
		// run out the reset countdowns before the directed items
		for (i = 0; i < 100; i++) ticks_to_send.push_back(tick_t'(4'b0000));
		for (i = 0; i < 24; i++) ticks_to_send.push_back(tick_t'(directed[i]));
		drain();

		for (i = 0; i < 4; i++) begin
			c = pick_settings();
			apply_settings(c);
			@(negedge clk);
			queue_button_runs(100, 2 * c.key_period + 2, 4'b1111);
			drain();
		end

		apply_settings('{16'd1, 16'd1, 16'd1, 8'd1, 12'd1, 12'd1});
		@(negedge clk);
		queue_button_runs(100, 3, 4'b1111);
		drain();

		c = pick_settings();
		c.toggles_per_set = PendingMax;
		c.dpi_step = 12'd4095;
		c.dpi_max = 12'd4095;
		apply_settings(c);
		@(negedge clk);
		queue_button_runs(100, 2 * c.key_period + 2, 4'b1111);
		drain();

		// pile up blink sets past saturation, then retire them two toggles at a time
		c = pick_settings();
		c.key_period = 16'd1;
		c.led_period = 16'd1;
		c.blink_interval = 16'hFFFF;
		apply_settings(c);
		@(negedge clk);
		for (i = 0; i < 520; i++) begin
			if ($urandom_range(0, 15) == 0) ticks_to_send.push_back(tick_t'($urandom_range(0, 15)));
			else ticks_to_send.push_back(tick_t'((i % 2) ? 4'b0000 : 4'b1000));
		end
		drain();

		c = pick_settings();
		c.key_period = 16'd1;
		c.led_period = 16'd1;
		c.blink_interval = 16'd1;
		c.toggles_per_set = 8'd2;
		apply_settings(c);
		@(negedge clk);
		queue_button_runs(220, 4, 4'b0111);
		drain();

		apply_settings('{16'hFFFF, 16'hFFFF, 16'hFFFF, PendingMax, 12'd4095, 12'd4095});
		@(negedge clk);
		queue_button_runs(60, 4, 4'b1111);
		drain();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && reports_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
sv/mbd_pkg.sv
sv/mbd_regs.sv
sv/mouse_button_dpi_controller.sv
tb/tb_mouse_button_dpi_controller.sv
